[hdl/group_min_priority_mask_core_defines.svh]
// ----------------------------------------------------------------------------
// group min priority mask assertion macros
// shared helpers for concurrent checks on the core's ports
// ----------------------------------------------------------------------------
`ifndef GROUP_MIN_PRIORITY_MASK_CORE_DEFINES_SVH
`define GROUP_MIN_PRIORITY_MASK_CORE_DEFINES_SVH

// clocked check that is off while reset is high
`define GMPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define GMPM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/gmpm_pkg.sv]
// ----------------------------------------------------------------------------
// gmpm_pkg
// field widths, constants and types of the group min priority mask core
// ----------------------------------------------------------------------------
package gmpm_pkg;

   localparam int GROUP_W = 6;
   localparam int PRIO_W  = 32;
   localparam int IDX_W   = 6;

   // value of a group that holds no open task
   localparam logic [PRIO_W-1:0] PRIO_NONE = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [GROUP_W-1:0] grp;
      logic [PRIO_W-1:0]  prio;
   } task_entry_type;

endpackage

[hdl/gmpm_req_if.sv]
// ----------------------------------------------------------------------------
// gmpm_req_if
// task channel: valid/ready handshake with one task per transfer
// ----------------------------------------------------------------------------
interface gmpm_req_if
   import gmpm_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [GROUP_W-1:0]       task_group;
   logic signed [PRIO_W-1:0] task_priority;
   logic                     task_done;
   logic                     row_last;

   modport source (output valid, output task_group, output task_priority,
                   output task_done, output row_last, input ready);
   modport sink   (input valid, input task_group, input task_priority,
                   input task_done, input row_last, output ready);
endinterface

[hdl/gmpm_rsp_if.sv]
// ----------------------------------------------------------------------------
// gmpm_rsp_if
// result channel: valid/ready handshake with one mask bit per transfer
// ----------------------------------------------------------------------------
interface gmpm_rsp_if
   import gmpm_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] task_index;
   logic             masked;
   logic             out_last;

   modport source (output valid, output task_index, output masked,
                   output out_last, input ready);
   modport sink   (input valid, input task_index, input masked,
                   input out_last, output ready);
endinterface

[hdl/group_min_priority_mask_core.sv]
// ----------------------------------------------------------------------------
// group_min_priority_mask_core: per-group minimum priority mask over one row
// load: one task per cycle; emit: one result per cycle while the output is
// not stalled; a row is loaded and then emitted, never both at once, as
// set by the single read port of the group minimum memory
// reset: synchronous, active high; clears control, counters and seen bits
// ----------------------------------------------------------------------------
module group_min_priority_mask_core
   import gmpm_pkg::*;
#(
   parameter int TASK_MAX  = 64,
   parameter int GROUP_MAX = 64
) (
   input  logic          clock,
   input  logic          reset,
   gmpm_req_if.sink      req_chan,
   gmpm_rsp_if.source    rsp_chan
);

   localparam int CNT_W  = $clog2(TASK_MAX + 1);
   localparam int TIDX_W = (TASK_MAX > 1) ? $clog2(TASK_MAX) : 1;
   localparam int GIDX_W = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // group index helpers: range check against the table depth and address
   function automatic logic grp_in_range(input logic [GROUP_W-1:0] grp);
      return {26'd0, grp} < 32'(GROUP_MAX);
   endfunction

   function automatic logic [GIDX_W-1:0] grp_addr(input logic [GROUP_W-1:0] grp);
      return GIDX_W'(grp);
   endfunction

   // memories: stored tasks of the row and per-group open minimum
   task_entry_type    task_mem [TASK_MAX];
   logic [PRIO_W-1:0] gmin_mem [GROUP_MAX];

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   emit_idx_ff;
   logic [GROUP_MAX-1:0] seen_ff;

   // load update stage
   logic               u_valid_ff;
   logic               u_open_ff;
   logic [GIDX_W-1:0]  u_gidx_ff;
   logic [PRIO_W-1:0]  u_prio_ff;

   // forward of the write made at the previous edge
   logic               fwd_valid_ff;
   logic [GIDX_W-1:0]  fwd_gidx_ff;
   logic [PRIO_W-1:0]  fwd_prio_ff;

   // memory read data
   task_entry_type     task_rd_ff;
   logic [PRIO_W-1:0]  gmin_rd_ff;

   // emission pipeline
   logic               a_valid_ff;
   logic [CNT_W-1:0]   a_idx_ff;
   logic               a_last_ff;
   logic               b_valid_ff;
   logic [CNT_W-1:0]   b_idx_ff;
   logic               b_last_ff;
   logic [PRIO_W-1:0]  b_prio_ff;
   logic               b_seen_ff;

   // output register
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic               rsp_masked_ff;
   logic               rsp_last_ff;

   logic               req_xfer;
   logic               row_close;
   logic [CNT_W-1:0]   cnt_inc;
   logic [PRIO_W-1:0]  cur_min;
   logic               take;
   logic               emit_adv;
   logic               emit_issue;
   logic [CNT_W-1:0]   emit_idx_inc;
   logic               rsp_done;
   logic               gmin_rd_en;
   logic [GIDX_W-1:0]  gmin_rd_addr;
   logic               masked_in;
   task_entry_type     req_entry;

   // tasks only enter while loading; emission owns the table read port
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign cnt_inc        = cnt_ff + 1'b1;
   // row closes on its last flag or when the task store fills up
   assign row_close      = req_chan.row_last || (cnt_inc == CNT_W'(TASK_MAX));
   assign req_entry.grp  = req_chan.task_group;
   assign req_entry.prio = req_chan.task_priority;

   // read-modify-write of the group minimum; a back-to-back task of the same
   // group must see the value written by the task just before it
   assign cur_min = (fwd_valid_ff && (fwd_gidx_ff == u_gidx_ff)) ? fwd_prio_ff : gmin_rd_ff;
   assign take    = u_valid_ff && u_open_ff &&
                    (!seen_ff[u_gidx_ff] || ($signed(u_prio_ff) < $signed(cur_min)));

   // emission pipeline moves whenever the output register can take a result
   assign emit_adv     = !(rsp_valid_ff && !rsp_chan.ready);
   assign emit_issue   = (state_ff == ST_EMIT) && emit_adv && (emit_idx_ff != n_ff);
   assign emit_idx_inc = emit_idx_ff + 1'b1;
   assign rsp_done     = rsp_valid_ff && rsp_chan.ready && rsp_last_ff;

   // one read port on the minimum table: task lookup while loading,
   // stored group lookup while emitting
   assign gmin_rd_en   = req_xfer || (emit_adv && a_valid_ff);
   assign gmin_rd_addr = (state_ff == ST_LOAD) ? grp_addr(req_chan.task_group)
                                               : grp_addr(task_rd_ff.grp);

   // a group with no open task compares against the largest signed value
   assign masked_in = (b_prio_ff != (b_seen_ff ? gmin_rd_ff : PRIO_NONE));

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.task_index = rsp_idx_ff;
   assign rsp_chan.masked     = rsp_masked_ff;
   assign rsp_chan.out_last   = rsp_last_ff;

   // task store: written at the row position, read in arrival order
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         task_mem[cnt_ff[TIDX_W-1:0]] <= req_entry;
      end
      if (emit_issue) begin
         task_rd_ff <= task_mem[emit_idx_ff[TIDX_W-1:0]];
      end
   end

   // group minimum table
   always_ff @(posedge clock) begin
      if (take) begin
         gmin_mem[u_gidx_ff] <= u_prio_ff;
      end
      if (gmin_rd_en) begin
         gmin_rd_ff <= gmin_mem[gmin_rd_addr];
      end
   end

   // control, pipeline and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         emit_idx_ff  <= '0;
         seen_ff      <= '0;
         u_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load update stage
         u_valid_ff <= req_xfer;
         if (req_xfer) begin
            u_open_ff <= !req_chan.task_done && grp_in_range(req_chan.task_group);
            u_gidx_ff <= grp_addr(req_chan.task_group);
            u_prio_ff <= req_chan.task_priority;
         end
         fwd_valid_ff <= take;
         fwd_gidx_ff  <= u_gidx_ff;
         fwd_prio_ff  <= u_prio_ff;
         if (take) begin
            seen_ff[u_gidx_ff] <= 1'b1;
         end

         case (state_ff)
            ST_LOAD: begin
               if (req_xfer) begin
                  if (row_close) begin
                     state_ff    <= ST_EMIT;
                     n_ff        <= cnt_inc;
                     cnt_ff      <= '0;
                     emit_idx_ff <= '0;
                  end else begin
                     cnt_ff <= cnt_inc;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_issue) begin
                  emit_idx_ff <= emit_idx_inc;
               end
               // last transfer of the row: clear the seen bits for the next row
               if (rsp_done) begin
                  state_ff    <= ST_LOAD;
                  emit_idx_ff <= '0;
                  seen_ff     <= '0;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase

         // emission pipeline: task read, group lookup, compare
         if (emit_adv) begin
            a_valid_ff <= emit_issue;
            a_idx_ff   <= emit_idx_ff;
            a_last_ff  <= (emit_idx_inc == n_ff);

            b_valid_ff <= a_valid_ff;
            b_idx_ff   <= a_idx_ff;
            b_last_ff  <= a_last_ff;
            b_prio_ff  <= task_rd_ff.prio;
            b_seen_ff  <= grp_in_range(task_rd_ff.grp) && seen_ff[grp_addr(task_rd_ff.grp)];

            rsp_valid_ff  <= b_valid_ff;
            rsp_idx_ff    <= IDX_W'(b_idx_ff);
            rsp_masked_ff <= masked_in;
            rsp_last_ff   <= b_last_ff;
         end
      end
   end

endmodule

[hdl/gmpm_checker.sv]
// ----------------------------------------------------------------------------
// gmpm_checker
// port-level checks on the group min priority mask core
// ----------------------------------------------------------------------------
`include "group_min_priority_mask_core_defines.svh"

module gmpm_checker
   import gmpm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_row_last,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_task_index,
   input logic             rsp_masked,
   input logic             rsp_out_last
);

   // a stalled result keeps its payload
   `GMPM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_task_index) && $stable(rsp_masked) && $stable(rsp_out_last)), "stalled result changed")

   // no task is taken while results of a row are being shown
   `GMPM_ASSERT(a_no_load_in_emit, clock, reset, rsp_valid |-> !req_ready, "task taken during emission")

   // a closing task stops intake for the emission that follows
   `GMPM_ASSERT(a_close_stops_load, clock, reset, (req_valid && req_ready && req_row_last) |=> !req_ready, "intake open after row close")

   // the last result of a row leaves the output empty
   `GMPM_ASSERT(a_last_drains, clock, reset, (rsp_valid && rsp_ready && rsp_out_last) |=> !rsp_valid, "result after row end")

endmodule

bind group_min_priority_mask_core gmpm_checker u_gmpm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_row_last   (req_chan.row_last),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_task_index (rsp_chan.task_index),
   .rsp_masked     (rsp_chan.masked),
   .rsp_out_last   (rsp_chan.out_last)
);
